// File: rtl/sha_pkg.sv
// sha-256 package: hash constants, round constants and round functions
// used by the front, the block engine and the top level
package sha_pkg;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_APPEND_FINISH = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef logic [31:0] word_t;

  // command from the front to the engine: one complete block to compress
  typedef struct packed {
    logic [511:0] block;
    logic         last;   // emit digest and restart after this block
  } blk_cmd_t;

  localparam word_t [0:7] INIT_VECTOR = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t [0:63] ROUND_CONST = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t sml_s0(input word_t x);
    sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_s1(input word_t x);
    sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: rtl/sha_front.sv
// sha-256 front: packs bytes into blocks, applies padding on finish
// depends on sha_pkg; issues blk_cmd_t towards the block queue
module sha_front import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output blk_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_FILL = 3'b001,
    S_PAD  = 3'b010,
    S_LEN  = 3'b100
  } fstate_t;

  fstate_t      state;
  logic [511:0] block;
  logic [5:0]   fill_count;
  logic [60:0]  message_bytes;
  logic         cmd_pend;
  logic         has_byte;
  logic         finish;
  logic [511:0] pad_block;
  logic [511:0] len_block;

  assign has_byte = (action == ACT_APPEND) || (action == ACT_APPEND_FINISH);
  assign finish = (action == ACT_APPEND_FINISH) || (action == ACT_FINISH);
  assign in_ready = (state == S_FILL) && !cmd_pend;
  assign cmd_valid = cmd_pend;

  // byte i of the block sits at bits [511-8i -: 8]
  always_comb begin
    pad_block = block;
    for (int i = 0; i < 64; i++) begin
      if (i[5:0] == fill_count) pad_block[511 - 8 * i -: 8] = 8'h80;
      else if (i[5:0] > fill_count) pad_block[511 - 8 * i -: 8] = 8'h00;
    end
    len_block = {pad_block[511:64], message_bytes, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      fill_count <= '0;
      message_bytes <= '0;
      cmd_pend <= 1'b0;
    end else begin
      if (cmd_pend && cmd_ready) cmd_pend <= 1'b0;
      case (state)
        S_FILL: begin
          if (in_valid && in_ready) begin
            if (has_byte) begin
              block[511 - 8 * fill_count -: 8] <= data_byte;
              message_bytes <= message_bytes + 61'd1;
              fill_count <= fill_count + 6'd1;
              if (fill_count == 6'd63) begin
                cmd.block <= {block[511:8], data_byte};
                cmd.last <= 1'b0;
                cmd_pend <= 1'b1;
              end
            end
            if (finish) state <= S_PAD;
          end
        end
        S_PAD: begin
          if (!cmd_pend) begin
            if (fill_count >= 6'd56) begin
              cmd.block <= pad_block;
              cmd.last <= 1'b0;
              cmd_pend <= 1'b1;
              block <= '0;
              fill_count <= '0;
              state <= S_LEN;
            end else begin
              cmd.block <= len_block;
              cmd.last <= 1'b1;
              cmd_pend <= 1'b1;
              fill_count <= '0;
              message_bytes <= '0;
              state <= S_FILL;
            end
          end
        end
        S_LEN: begin
          if (!cmd_pend) begin
            cmd.block <= {448'd0, message_bytes, 3'b000};
            cmd.last <= 1'b1;
            cmd_pend <= 1'b1;
            message_bytes <= '0;
            state <= S_FILL;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

endmodule

// File: rtl/sha_queue.sv
// two-entry block queue between front and engine
// depends on sha_pkg for blk_cmd_t
module sha_queue import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  blk_cmd_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output blk_cmd_t rd_data
);

  blk_cmd_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = mem[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/sha_engine.sv
// sha-256 block engine: one round per cycle, hash update, digest output
// depends on sha_pkg; takes blocks from the queue, drives the result stream
module sha_engine import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  blk_cmd_t    cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    E_IDLE  = 3'b001,
    E_ROUND = 3'b010,
    E_EMIT  = 3'b100
  } estate_t;

  estate_t    state;
  word_t      hash_words [8];
  word_t      wv [8];
  word_t      sched [16];
  logic [5:0] round_count;
  logic       last_blk;
  logic [2:0] emit_idx;
  word_t      w;
  word_t      t1;
  word_t      t2;

  assign cmd_ready = state == E_IDLE;
  assign out_valid = state == E_EMIT;
  assign digest_word = hash_words[emit_idx];
  assign word_index = emit_idx;
  assign last_word = emit_idx == 3'd7;

  // window holds w[r..r+15]; the round uses the head, the new word is computed from the window
  always_comb begin
    w = sched[0];
    t1 = wv[7] + big_s1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + ROUND_CONST[round_count] + w;
    t2 = big_s0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      round_count <= '0;
      emit_idx <= '0;
      last_blk <= 1'b0;
      for (int i = 0; i < 8; i++) hash_words[i] <= INIT_VECTOR[i];
    end else begin
      case (state)
        E_IDLE: begin
          if (cmd_valid) begin
            for (int i = 0; i < 16; i++) sched[i] <= cmd.block[511 - 32 * i -: 32];
            for (int i = 0; i < 8; i++) wv[i] <= hash_words[i];
            last_blk <= cmd.last;
            round_count <= '0;
            state <= E_ROUND;
          end
        end
        E_ROUND: begin
          for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
          sched[15] <= sml_s1(sched[14]) + sched[9] + sml_s0(sched[1]) + sched[0];
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          round_count <= round_count + 6'd1;
          if (round_count == 6'd63) begin
            // add the post-round working variables into the hash
            hash_words[0] <= hash_words[0] + t1 + t2;
            for (int i = 1; i < 8; i++) begin
              if (i != 4) hash_words[i] <= hash_words[i] + wv[i - 1];
            end
            hash_words[4] <= hash_words[4] + wv[3] + t1;
            emit_idx <= '0;
            state <= last_blk ? E_EMIT : E_IDLE;
          end
        end
        E_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_words[i] <= INIT_VECTOR[i];
              state <= E_IDLE;
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  a_emit_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == E_ROUND && emit_idx == 3'd0))
    else $error("digest emitted without finishing a block");
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(emit_idx))
    else $error("word index moved while stalled");
  a_round_zero_idle: assert property (@(posedge clk) disable iff (rst)
    (state == E_IDLE) |-> (round_count == 6'd0))
    else $error("round count not cleared");

endmodule

// File: rtl/sha256_message_hash.sv
// sha-256 streaming hash: top level joining front, queue and engine
// depends on sha_pkg, sha_front, sha_queue, sha_engine
// the engine takes a new block only once it is through with the last one
// about one byte per cycle sustained while the result stream does not stall
// a finish adds one or two padded blocks, then 8 result transfers
// reset is synchronous: hash restarts from the initial vector, queue empties
module sha256_message_hash import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte [7:0]
  input  logic [1:0]  s_tuser,   // action [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word [31:0], word_index [34:32], zeros
  output logic        m_tlast    // last_word
);

  blk_cmd_t    f_cmd;
  blk_cmd_t    q_cmd;
  logic        f_valid;
  logic        f_ready;
  logic        q_valid;
  logic        q_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sha_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .action(s_tuser), .data_byte(s_tdata),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  sha_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  sha_engine u_engine (
    .clk, .rst,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .digest_word(digest_word), .word_index(word_index), .last_word(m_tlast)
  );

  assign m_tdata = {5'd0, word_index, digest_word};

endmodule
